// ----- hdl/forth_data_stack_execute_unit_defines.svh -----
// Assertion macros shared by the data-stack execute unit RTL
`ifndef FORTH_DATA_STACK_EXECUTE_UNIT_DEFINES_SVH
`define FORTH_DATA_STACK_EXECUTE_UNIT_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off while rst_n is low
`define FDSE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define FDSE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FDSE_ASSERT_IMP(label, ante, cons, msg)
`define FDSE_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ----- hdl/fdse_pkg.sv -----
// Shared types, operation codes and status codes of the data-stack execute unit
`default_nettype none

package fdse_pkg;

    localparam int DATA_W          = 32;
    localparam int FUNC_W          = 5;
    localparam int DEPTH_W         = 7;
    localparam int STACK_DEPTH_DEF = 64;

    typedef logic [DATA_W-1:0] word_t;

    // operation codes
    localparam logic [FUNC_W-1:0] F_PUSH  = 5'd0;
    localparam logic [FUNC_W-1:0] F_ADD   = 5'd1;
    localparam logic [FUNC_W-1:0] F_SUB   = 5'd2;
    localparam logic [FUNC_W-1:0] F_MUL   = 5'd3;
    localparam logic [FUNC_W-1:0] F_DIV   = 5'd4;
    localparam logic [FUNC_W-1:0] F_MOD   = 5'd5;
    localparam logic [FUNC_W-1:0] F_NEG   = 5'd6;
    localparam logic [FUNC_W-1:0] F_PRINT = 5'd7;
    localparam logic [FUNC_W-1:0] F_DUP   = 5'd8;
    localparam logic [FUNC_W-1:0] F_DROP  = 5'd9;
    localparam logic [FUNC_W-1:0] F_SWAP  = 5'd10;
    localparam logic [FUNC_W-1:0] F_ROT   = 5'd11;
    localparam logic [FUNC_W-1:0] F_LT    = 5'd12;
    localparam logic [FUNC_W-1:0] F_LE    = 5'd13;
    localparam logic [FUNC_W-1:0] F_EQ    = 5'd14;
    localparam logic [FUNC_W-1:0] F_NE    = 5'd15;
    localparam logic [FUNC_W-1:0] F_GT    = 5'd16;
    localparam logic [FUNC_W-1:0] F_GE    = 5'd17;
    localparam logic [FUNC_W-1:0] F_AND   = 5'd18;
    localparam logic [FUNC_W-1:0] F_OR    = 5'd19;
    localparam logic [FUNC_W-1:0] F_NOT   = 5'd20;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_UNDER = 2'd1;
    localparam logic [1:0] STAT_OVER  = 2'd2;
    localparam logic [1:0] STAT_DIVZ  = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic signed [DATA_W-1:0] push_value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] top_value;
        logic [DEPTH_W-1:0]       depth;
        logic                     print_valid;
        logic signed [DATA_W-1:0] print_value;
    } rsp_t;

endpackage

`default_nettype wire

// ----- hdl/fdse_stack_ram.sv -----
// Stack storage below the top entry: two synchronous read ports, one write port
`default_nettype none

module fdse_stack_ram
    import fdse_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire word_t         wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr_a,
    input  wire logic [AW-1:0] rd_addr_b,
    output word_t              rd_data_a,
    output word_t              rd_data_b
);

    word_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/fdse_div.sv -----
// Signed truncating divider, restoring, one quotient bit per cycle
`default_nettype none

module fdse_div
    import fdse_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  wire word_t dividend,
    input  wire word_t divisor,
    output logic       busy,
    output word_t      quotient,
    output word_t      remainder
);

    localparam int CNT_W = $clog2(DATA_W);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            rem_reg, rem_next;
    word_t            quo_reg, quo_next;
    word_t            den_reg, den_next;
    logic             neg_q_reg, neg_q_next;
    logic             neg_r_reg, neg_r_next;
    logic [DATA_W:0]  trial;

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        trial      = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, den_reg};

        if (start)
        begin
            // work on magnitudes; the most negative value stays as its unsigned magnitude
            rem_next   = '0;
            quo_next   = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            den_next   = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            neg_q_next = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            neg_r_next = dividend[DATA_W-1];
            cnt_next   = CNT_W'(DATA_W - 1);
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]};
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        den_reg   <= den_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    assign busy      = busy_reg;
    assign quotient  = neg_q_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign remainder = neg_r_reg ? (~rem_reg + 1'b1) : rem_reg;

endmodule

`default_nettype wire

// ----- hdl/forth_data_stack_execute_unit.sv -----
// Top level of the Forth-style data-stack execute unit
//
//   channel | direction | handshake           | payload
//   cmd     | in        | cmd_valid/cmd_stall | cmd_t: func, push_value
//   rsp     | out       | rsp_valid/rsp_stall | rsp_t: status, top_value, depth, print
//
// One transaction at a time. Most operations pass through accept (ST_IDLE) and execute (ST_EXEC);
// rot adds ST_ROT because the single memory write port needs two writes.
// div and mod wait in ST_DIV for the divider, which makes one quotient bit per cycle.
// Top of stack lives in a register; deeper entries live in the RAM.
// Reset clears the count and the handshakes; no RAM clearing is needed.
// A stalled rsp holds the next operation in its execute state.
`default_nettype none
`include "forth_data_stack_execute_unit_defines.svh"

module forth_data_stack_execute_unit
    import fdse_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_stall,
    input  wire cmd_t cmd,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_ROT  = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    cmd_t          item_reg, item_next;
    logic [CW-1:0] count_reg, count_next;
    word_t         top_reg, top_next;
    rsp_t          rsp_reg, rsp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    logic          accept;
    logic          rsp_free;
    logic [CW-1:0] cnt_p1, cnt_m1, cnt_m2, cnt_m3;
    logic [1:0]    need;
    logic          under;
    logic          full;
    logic          fin;
    logic [1:0]    stat;
    logic          pv;
    word_t         pval;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    word_t         wr_data;
    word_t         rd_a, rd_b;

    logic          div_start;
    logic          div_busy;
    word_t         div_quo, div_rem;

    function automatic logic [1:0] operand_need(input logic [FUNC_W-1:0] f);
        logic [1:0] n;
        case (f)
            F_ADD, F_SUB, F_MUL, F_DIV, F_MOD, F_SWAP,
            F_LT, F_LE, F_EQ, F_NE, F_GT, F_GE, F_AND, F_OR: n = 2'd2;
            F_NEG, F_PRINT, F_DUP, F_DROP, F_NOT:              n = 2'd1;
            F_ROT:                                             n = 2'd3;
            default:                                           n = 2'd0;
        endcase
        return n;
    endfunction

    // second op top for the binary operations
    function automatic word_t bin_op(input logic [FUNC_W-1:0] f, input word_t a,
                                     input word_t b);
        word_t r;
        logic  a_true;
        logic  b_true;
        a_true = (a != '0) && !a[DATA_W-1];
        b_true = (b != '0) && !b[DATA_W-1];
        case (f)
            F_ADD:   r = a + b;
            F_SUB:   r = a - b;
            F_MUL:   r = a * b;
            F_LT:    r = word_t'($signed(a) < $signed(b));
            F_LE:    r = word_t'(!($signed(b) < $signed(a)));
            F_EQ:    r = word_t'(a == b);
            F_NE:    r = word_t'(a != b);
            F_GT:    r = word_t'($signed(b) < $signed(a));
            F_GE:    r = word_t'(!($signed(a) < $signed(b)));
            F_AND:   r = word_t'(a_true && b_true);
            default: r = word_t'(a_true || b_true);
        endcase
        return r;
    endfunction

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;

    assign cnt_p1 = count_reg + CW'(1);
    assign cnt_m1 = count_reg - CW'(1);
    assign cnt_m2 = count_reg - CW'(2);
    assign cnt_m3 = count_reg - CW'(3);

    assign need  = operand_need(item_reg.func);
    assign under = (count_reg < CW'(need));
    assign full  = (count_reg == CW'(STACK_DEPTH));

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        wr_en          = 1'b0;
        wr_addr        = cnt_m1[AW-1:0];
        wr_data        = top_reg;
        div_start      = 1'b0;
        fin            = 1'b0;
        stat           = STAT_OK;
        pv             = 1'b0;
        pval           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next  = cmd;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (rsp_free)
                begin
                    if (item_reg.func > F_NOT)
                    begin
                        fin = 1'b1;
                    end
                    else if (under)
                    begin
                        fin  = 1'b1;
                        stat = STAT_UNDER;
                    end
                    else
                    begin
                        case (item_reg.func)
                            F_PUSH:
                            begin
                                fin = 1'b1;
                                if (full)
                                begin
                                    stat = STAT_OVER;
                                end
                                else
                                begin
                                    // old top spills into the RAM
                                    wr_en      = (count_reg != '0);
                                    top_next   = item_reg.push_value;
                                    count_next = cnt_p1;
                                end
                            end
                            F_DUP:
                            begin
                                fin = 1'b1;
                                if (full)
                                begin
                                    stat = STAT_OVER;
                                end
                                else
                                begin
                                    wr_en      = 1'b1;
                                    count_next = cnt_p1;
                                end
                            end
                            F_DIV, F_MOD:
                            begin
                                if (top_reg == '0)
                                begin
                                    fin  = 1'b1;
                                    stat = STAT_DIVZ;
                                end
                                else
                                begin
                                    div_start  = 1'b1;
                                    state_next = ST_DIV;
                                end
                            end
                            F_NEG:
                            begin
                                fin      = 1'b1;
                                top_next = ~top_reg + 1'b1;
                            end
                            F_NOT:
                            begin
                                fin      = 1'b1;
                                top_next = word_t'(top_reg == '0);
                            end
                            F_PRINT:
                            begin
                                fin        = 1'b1;
                                pv         = 1'b1;
                                pval       = top_reg;
                                top_next   = rd_a;
                                count_next = cnt_m1;
                            end
                            F_DROP:
                            begin
                                fin        = 1'b1;
                                top_next   = rd_a;
                                count_next = cnt_m1;
                            end
                            F_SWAP:
                            begin
                                fin      = 1'b1;
                                wr_en    = 1'b1;
                                wr_addr  = cnt_m2[AW-1:0];
                                top_next = rd_a;
                            end
                            F_ROT:
                            begin
                                // first write now, second in ST_ROT
                                wr_en      = 1'b1;
                                wr_addr    = cnt_m3[AW-1:0];
                                wr_data    = rd_a;
                                state_next = ST_ROT;
                            end
                            default:
                            begin
                                fin        = 1'b1;
                                top_next   = bin_op(item_reg.func, rd_a, top_reg);
                                count_next = cnt_m1;
                            end
                        endcase
                    end
                end
            end
            ST_DIV:
            begin
                if (rsp_free && !div_busy)
                begin
                    fin        = 1'b1;
                    top_next   = (item_reg.func == F_DIV) ? div_quo : div_rem;
                    count_next = cnt_m1;
                end
            end
            ST_ROT:
            begin
                if (rsp_free)
                begin
                    fin      = 1'b1;
                    wr_en    = 1'b1;
                    wr_addr  = cnt_m2[AW-1:0];
                    wr_data  = top_reg;
                    top_next = rd_b;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin)
        begin
            state_next           = ST_IDLE;
            rsp_valid_next       = 1'b1;
            rsp_next.status      = stat;
            rsp_next.top_value   = (count_next == '0) ? '0 : top_next;
            rsp_next.depth       = DEPTH_W'(count_next);
            rsp_next.print_valid = pv;
            rsp_next.print_value = pval;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        top_reg  <= top_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // second and third entries are fetched as the transaction is accepted;
    // writes land before the next accept, so no forwarding is needed
    fdse_stack_ram #(
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (accept),
        .rd_addr_a (cnt_m2[AW-1:0]),
        .rd_addr_b (cnt_m3[AW-1:0]),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    fdse_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rd_a),
        .divisor   (top_reg),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    `FDSE_ASSERT_IMP(a_count_range, 1'b1, count_reg <= CW'(STACK_DEPTH), "stack count out of range")
    `FDSE_ASSERT_NXT(a_accept_exec, accept, state_reg == ST_EXEC, "accepted command not executing")
    `FDSE_ASSERT_NXT(a_error_keeps, fin && stat != STAT_OK, $stable(count_reg), "failed op moved count")
    `FDSE_ASSERT_IMP(a_div_owner, div_busy, state_reg == ST_DIV, "divider busy outside divide state")

endmodule

`default_nettype wire
